FILE: rtl/cfd_pkg.sv
// Shared types and constants for the CPPM frame decoder.
// No dependencies; used by every other file in rtl/.
package cfd_pkg;

    localparam int RegAddrBits = 4;   // four 32-bit registers at byte offsets 0..12
    localparam int DataBits    = 32;

    typedef enum logic [1:0] {
        REG_ENABLE  = 2'd0,
        REG_GAP     = 2'd1,
        REG_MIN     = 2'd2,
        REG_MAX     = 2'd3
    } reg_index_t;

    typedef enum logic {
        OP_CAPTURE = 1'b0,
        OP_CLEAR   = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        EV_FRAME    = 3'd0,
        EV_CHANNEL  = 3'd1,
        EV_REJECT   = 3'd2,
        EV_NONE     = 3'd3,
        EV_OVERFLOW = 3'd4
    } event_kind_t;

    localparam logic [15:0] GapReset = 16'd3000;
    localparam logic [15:0] MinReset = 16'd800;
    localparam logic [15:0] MaxReset = 16'd2200;
    localparam logic [15:0] WidthSat = 16'hFFFF;

    typedef struct packed {
        logic        enable;
        logic [15:0] gap_threshold;
        logic [15:0] min_pulse;
        logic [15:0] max_pulse;
    } cfg_t;

    typedef struct packed {
        event_kind_t kind;
        logic [3:0]  channel_index;
        logic [15:0] pulse_width;
        logic [15:0] decoded_mask;
        logic        frame_valid;
        logic [31:0] frame_time;
    } result_t;

endpackage

FILE: rtl/cfd_apb_regs.sv
// APB configuration registers of the CPPM frame decoder.
// Depends on cfd_pkg (register indexes, reset values, cfg_t).
module cfd_apb_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cfd_pkg::RegAddrBits-1:0]  paddr,
    input  logic [cfd_pkg::DataBits-1:0]     pwdata,
    output logic [cfd_pkg::DataBits-1:0]     prdata,
    output logic                             pready,
    output cfd_pkg::cfg_t                    cfg
);

    cfd_pkg::cfg_t      cfg_reg;
    cfd_pkg::reg_index_t idx;
    logic               wr_en;

    assign idx    = cfd_pkg::reg_index_t'(paddr[3:2]);
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable        <= 1'b0;
            cfg_reg.gap_threshold <= cfd_pkg::GapReset;
            cfg_reg.min_pulse     <= cfd_pkg::MinReset;
            cfg_reg.max_pulse     <= cfd_pkg::MaxReset;
        end
        else if (wr_en)
        begin
            unique case (idx)
                cfd_pkg::REG_ENABLE: cfg_reg.enable        <= pwdata[0];
                cfd_pkg::REG_GAP:    cfg_reg.gap_threshold <= pwdata[15:0];
                cfd_pkg::REG_MIN:    cfg_reg.min_pulse     <= pwdata[15:0];
                cfd_pkg::REG_MAX:    cfg_reg.max_pulse     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            cfd_pkg::REG_ENABLE: prdata = {31'd0, cfg_reg.enable};
            cfd_pkg::REG_GAP:    prdata = {16'd0, cfg_reg.gap_threshold};
            cfd_pkg::REG_MIN:    prdata = {16'd0, cfg_reg.min_pulse};
            cfd_pkg::REG_MAX:    prdata = {16'd0, cfg_reg.max_pulse};
            default:             prdata = '0;
        endcase
    end

endmodule

FILE: rtl/cfd_decode.sv
// Decoder state and its next-state logic for the CPPM frame decoder.
// Depends on cfd_pkg (op_t, event_kind_t, cfg_t, result_t).
module cfd_decode
#(
    parameter int COUNTER_BITS = 16,
    parameter int MAX_CHANNELS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic                operation,
    input  logic [15:0]         capture_value,
    input  logic [31:0]         now_time,
    input  cfd_pkg::cfg_t       cfg,
    output cfd_pkg::result_t    result
);

    // usable channels are bounded by the 16-bit mask
    localparam int ChanLimit = (MAX_CHANNELS > 16) ? 16 : MAX_CHANNELS;

    logic [15:0] prev_reg,       prev_next;
    logic [4:0]  next_chan_reg,  next_chan_next;
    logic        frame_ok_reg,   frame_ok_next;
    logic [15:0] mask_reg,       mask_next;
    logic [31:0] frame_time_reg, frame_time_next;

    logic [31:0]             cap_wide;
    logic [31:0]             prev_wide;
    logic [COUNTER_BITS-1:0] interval;
    logic [31:0]             interval_wide;
    logic                    is_gap;
    logic                    in_range;
    logic                    has_room;
    cfd_pkg::event_kind_t    kind;
    logic [3:0]              chan;
    logic [15:0]             width;

    assign cap_wide      = {16'd0, capture_value};
    assign prev_wide     = {16'd0, prev_reg};
    // modulo-2^COUNTER_BITS difference handles counter wrap
    assign interval      = cap_wide[COUNTER_BITS-1:0] - prev_wide[COUNTER_BITS-1:0];
    assign interval_wide = 32'(interval);
    assign is_gap        = interval_wide > {16'd0, cfg.gap_threshold};
    assign in_range      = (interval_wide > {16'd0, cfg.min_pulse})
                        && (interval_wide < {16'd0, cfg.max_pulse});
    assign has_room      = next_chan_reg < 5'(ChanLimit);

    always_comb
    begin
        prev_next       = prev_reg;
        next_chan_next  = next_chan_reg;
        frame_ok_next   = frame_ok_reg;
        mask_next       = mask_reg;
        frame_time_next = frame_time_reg;
        kind            = cfd_pkg::EV_NONE;
        chan            = 4'd0;
        width           = 16'd0;

        if (cfd_pkg::op_t'(operation) == cfd_pkg::OP_CLEAR)
        begin
            mask_next = 16'd0;
        end
        else
        begin
            width     = (interval_wide > 32'(cfd_pkg::WidthSat)) ? cfd_pkg::WidthSat
                                                                  : interval_wide[15:0];
            prev_next = capture_value;
            if (cfg.enable)
            begin
                if (is_gap)
                begin
                    frame_time_next = now_time;
                    next_chan_next  = 5'd0;
                    frame_ok_next   = 1'b1;
                    kind            = cfd_pkg::EV_FRAME;
                end
                else if (in_range && frame_ok_reg)
                begin
                    if (has_room)
                    begin
                        chan           = next_chan_reg[3:0];
                        mask_next      = mask_reg | (16'd1 << chan);
                        next_chan_next = next_chan_reg + 5'd1;
                        kind           = cfd_pkg::EV_CHANNEL;
                    end
                    else
                    begin
                        kind = cfd_pkg::EV_OVERFLOW;
                    end
                end
                else
                begin
                    frame_ok_next = 1'b0;
                    kind          = cfd_pkg::EV_REJECT;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg       <= '0;
            next_chan_reg  <= '0;
            frame_ok_reg   <= 1'b0;
            mask_reg       <= '0;
            frame_time_reg <= '0;
        end
        else if (fire)
        begin
            prev_reg       <= prev_next;
            next_chan_reg  <= next_chan_next;
            frame_ok_reg   <= frame_ok_next;
            mask_reg       <= mask_next;
            frame_time_reg <= frame_time_next;
        end
    end

    assign result.kind          = kind;
    assign result.channel_index = chan;
    assign result.pulse_width   = width;
    assign result.decoded_mask  = mask_next;
    assign result.frame_valid   = frame_ok_next;
    assign result.frame_time    = frame_time_next;

endmodule

FILE: rtl/cppm_frame_decoder_core.sv
// Top level of the CPPM frame decoder: input register, decode step, result register.
// Depends on cfd_pkg, cfd_apb_regs and cfd_decode.
//
// Usage notes:
//  - Input channel (in_valid / in_stall): one item per capture event or mask
//    clear. An item is taken at a clock edge with in_valid high, in_stall low.
//  - Output channel (out_valid / out_stall): exactly one result item per
//    input item, in order.
//  - The item lands in the input register at the accepting edge and its result
//    in the result register when it moves on (fire), which waits while a
//    stalled result holds the result register. Throughput: 1 item per cycle
//    while out_stall stays low; the decode step is one subtract and five
//    compares between the two registers.
//  - A stalled result holds in the result register while one more item can
//    wait in the input register; in_stall rises only when both are full.
//  - Reset (rst_n low, async) empties both stages, clears decoder state to
//    zero and loads register defaults: disabled, gap 3000, min 800, max 2200.
//  - Configuration goes through the APB port (always ready). The user keeps it
//    written only while no item is in flight; the block does not enforce this.
module cppm_frame_decoder_core
#(
    parameter int COUNTER_BITS = 16,
    parameter int MAX_CHANNELS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input items
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [15:0] capture_value,
    input  logic [31:0] now_time,
    // result items
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_kind,
    output logic [3:0]  channel_index,
    output logic [15:0] pulse_width,
    output logic [15:0] decoded_mask,
    output logic        frame_valid,
    output logic [31:0] frame_time
);

    cfd_pkg::cfg_t    cfg;
    cfd_pkg::result_t step_result;

    // input stage
    logic        s1_valid_reg, s1_valid_next;
    logic        s1_op_reg;
    logic [15:0] s1_cap_reg;
    logic [31:0] s1_now_reg;

    // result stage
    logic             out_valid_reg, out_valid_next;
    cfd_pkg::result_t res_reg;

    logic in_take;   // item enters the input stage
    logic out_free;  // result register can load this cycle
    logic fire;      // item moves from input stage to result register

    assign out_free = !out_valid_reg || !out_stall;
    assign fire     = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    assign s1_valid_next  = in_take || (s1_valid_reg && !fire);
    assign out_valid_next = out_free ? s1_valid_reg : out_valid_reg;

    cfd_apb_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cfd_decode
    #(
        .COUNTER_BITS (COUNTER_BITS),
        .MAX_CHANNELS (MAX_CHANNELS)
    )
    u_decode
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .operation     (s1_op_reg),
        .capture_value (s1_cap_reg),
        .now_time      (s1_now_reg),
        .cfg           (cfg),
        .result        (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_op_reg  <= operation;
            s1_cap_reg <= capture_value;
            s1_now_reg <= now_time;
        end
        if (fire)
        begin
            res_reg <= step_result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_kind    = res_reg.kind;
    assign channel_index = res_reg.channel_index;
    assign pulse_width   = res_reg.pulse_width;
    assign decoded_mask  = res_reg.decoded_mask;
    assign frame_valid   = res_reg.frame_valid;
    assign frame_time    = res_reg.frame_time;

endmodule

FILE: sim/cppm_decode_checker.sv
// Checker for the CPPM frame decoder: follows register writes, predicts one result per
// accepted item and compares it with the result channel. Depends on cfd_pkg.
module cppm_decode_checker
    import cfd_pkg::*;
#(
    parameter int COUNTER_BITS = 16,
    parameter int MAX_CHANNELS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        operation,
    input  logic [15:0] capture_value,
    input  logic [31:0] now_time,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  event_kind,
    input  logic [3:0]  channel_index,
    input  logic [15:0] pulse_width,
    input  logic [15:0] decoded_mask,
    input  logic        frame_valid,
    input  logic [31:0] frame_time,
    output int          fail_count,
    output int          pending
);

    localparam logic [63:0] TickMask = (COUNTER_BITS >= 32) ? 64'hFFFF_FFFF :
                                       (64'd1 << COUNTER_BITS) - 64'd1;
    localparam int ChanLimit = (MAX_CHANNELS > 16) ? 16 : MAX_CHANNELS;

    cfg_t        cfg;
    logic [15:0] last_cap;
    logic [4:0]  next_chan;
    logic        in_frame;
    logic [15:0] seen_mask;
    logic [31:0] frame_stamp;
    result_t     results_due[$];
    int          result_no;

    task automatic report_mismatch(string note);
        if (fail_count < 60)
            $display("checker: result %0d: %s", result_no, note);
        fail_count++;
    endtask

    // one decode step; updates the decoder copy and returns the result it gives
    function automatic result_t decode_item(logic op, logic [15:0] cap, logic [31:0] stamp);
        result_t     r;
        logic [63:0] span;
        r = '0;
        r.kind = EV_NONE;
        if (op_t'(op) == OP_CLEAR) begin
            seen_mask = '0;
        end else begin
            span = ({48'd0, cap} - {48'd0, last_cap}) & TickMask;
            r.pulse_width = (span > 64'hFFFF) ? WidthSat : span[15:0];
            if (cfg.enable) begin
                if (span > {48'd0, cfg.gap_threshold}) begin
                    frame_stamp = stamp;
                    next_chan = '0;
                    in_frame = 1'b1;
                    r.kind = EV_FRAME;
                end else if (span > {48'd0, cfg.min_pulse} && span < {48'd0, cfg.max_pulse}
                             && in_frame) begin
                    if (next_chan < ChanLimit) begin
                        r.channel_index = next_chan[3:0];
                        seen_mask = seen_mask | (16'd1 << next_chan[3:0]);
                        next_chan = next_chan + 5'd1;
                        r.kind = EV_CHANNEL;
                    end else begin
                        r.kind = EV_OVERFLOW;
                    end
                end else begin
                    in_frame = 1'b0;
                    r.kind = EV_REJECT;
                end
            end
            last_cap = cap;
        end
        r.decoded_mask = seen_mask;
        r.frame_valid = in_frame;
        r.frame_time = frame_stamp;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        result_t want;
        if (!rst_n) begin
            cfg = '{enable: 1'b0, gap_threshold: GapReset, min_pulse: MinReset,
                    max_pulse: MaxReset};
            last_cap = '0;
            next_chan = '0;
            in_frame = 1'b0;
            seen_mask = '0;
            frame_stamp = '0;
            results_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_index_t'(paddr[3:2]))
                    REG_ENABLE: cfg.enable = pwdata[0];
                    REG_GAP:    cfg.gap_threshold = pwdata[15:0];
                    REG_MIN:    cfg.min_pulse = pwdata[15:0];
                    REG_MAX:    cfg.max_pulse = pwdata[15:0];
                    default:    ;
                endcase
            end
            // a result never leaves at the edge that takes its item, so compare first
            if (out_valid && !out_stall) begin
                if (results_due.size() == 0) begin
                    report_mismatch("result with no item outstanding");
                end else begin
                    want = results_due.pop_front();
                    if (event_kind !== want.kind)
                        report_mismatch($sformatf("event_kind %0d, expected %0d",
                                                  event_kind, want.kind));
                    if (channel_index !== want.channel_index)
                        report_mismatch($sformatf("channel_index %0d, expected %0d",
                                                  channel_index, want.channel_index));
                    if (pulse_width !== want.pulse_width)
                        report_mismatch($sformatf("pulse_width %0d, expected %0d",
                                                  pulse_width, want.pulse_width));
                    if (decoded_mask !== want.decoded_mask)
                        report_mismatch($sformatf("decoded_mask %h, expected %h",
                                                  decoded_mask, want.decoded_mask));
                    if (frame_valid !== want.frame_valid)
                        report_mismatch($sformatf("frame_valid %b, expected %b",
                                                  frame_valid, want.frame_valid));
                    if (frame_time !== want.frame_time)
                        report_mismatch($sformatf("frame_time %h, expected %h",
                                                  frame_time, want.frame_time));
                end
                result_no++;
            end
            if (in_valid && !in_stall)
                results_due.push_back(decode_item(operation, capture_value, now_time));
        end
        pending = results_due.size();
    end

endmodule

FILE: sim/tb.sv
// Top of the CPPM frame decoder testbench: clock, reset, register writes, item stimulus
// and result-side stalls. Depends on cfd_pkg, cppm_frame_decoder_core, cppm_decode_checker.
module tb;

    import cfd_pkg::*;

    localparam int CounterBits  = 16;
    localparam int MaxChannels  = 16;
    localparam int SegmentItems = 135;     // random items per settings segment
    localparam int HoldCycles   = 300;     // long result-side hold-off
    localparam int CycleLimit   = 400000;  // far above the slowest clean run

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic        operation;
    logic [15:0] capture_value;
    logic [31:0] now_time;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  event_kind;
    logic [3:0]  channel_index;
    logic [15:0] pulse_width;
    logic [15:0] decoded_mask;
    logic        frame_valid;
    logic [31:0] frame_time;
    int          fail_count;
    int          pending;

    // stimulus-side view of the decoder, used only to shape well-formed frames
    logic [15:0] last_capture;
    logic [15:0] set_gap;
    logic [15:0] set_min;
    logic [15:0] set_max;
    int          idle_pct;      // chance in a hundred, per draw, that the sender idles
    int          stall_pct;     // chance in a hundred, per draw, that the receiver stalls
    bit          hold_request;  // asks the receiver for one long hold-off
    int          sent_items;
    int          cycle_count;

    cppm_frame_decoder_core #(
        .COUNTER_BITS(CounterBits),
        .MAX_CHANNELS(MaxChannels)
    ) uut (.*);

    cppm_decode_checker #(
        .COUNTER_BITS(CounterBits),
        .MAX_CHANNELS(MaxChannels)
    ) chk (.*);

    always #2 clk = ~clk;

    // watchdog: a hang or a lost result ends here
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // Result side. Stalls are drawn every falling edge; a hold-off request keeps the
    // channel stalled through one long hold-off so the two internal stages fill and in_stall rises.
    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                for (int k = 0; k < HoldCycles; k++) begin
                    out_stall <= 1'b1;
                    @(negedge clk);
                end
            end
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // APB write: setup cycle, then access cycle; the write lands on the edge with
    // psel, penable and pready all high.
    task automatic write_reg(reg_index_t idx, logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Sender pause: drop valid and wait until every outstanding result of the
    // two-stage pipe has left, before registers may change.
    task automatic wait_results_done();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic apply_settings(bit en, logic [15:0] gap, logic [15:0] lo, logic [15:0] hi);
        wait_results_done();
        write_reg(REG_ENABLE, {31'd0, en});
        write_reg(REG_GAP, {16'd0, gap});
        write_reg(REG_MIN, {16'd0, lo});
        write_reg(REG_MAX, {16'd0, hi});
        set_gap = gap;
        set_min = lo;
        set_max = hi;
    endtask

    // Offer one item and return at the edge that takes it. Valid is only touched
    // on falling edges, once per edge; the payload holds while stalled.
    task automatic send_item(op_t op, logic [15:0] cap, logic [31:0] stamp);
        int gap_len;
        gap_len = 0;
        while ($urandom_range(0, 99) < idle_pct && gap_len < 20)
            gap_len++;
        @(negedge clk);
        if (gap_len > 0) begin
            in_valid <= 1'b0;
            repeat (gap_len) @(negedge clk);
        end
        in_valid      <= 1'b1;
        operation     <= op;
        capture_value <= cap;
        now_time      <= stamp;
        do @(posedge clk); while (in_stall);
        if (op == OP_CAPTURE)
            last_capture = cap;
        sent_items++;
    endtask

    // capture placed a given number of ticks after the previous one (16-bit wrap)
    task automatic send_interval(logic [15:0] ticks);
        send_item(OP_CAPTURE, last_capture + ticks, $urandom);
    endtask

    // an interval that starts a frame under the current gap threshold
    function automatic logic [15:0] sync_ticks();
        if (set_gap == 16'hFFFF)
            return 16'($urandom);
        if ($urandom_range(0, 7) == 0)
            return set_gap + 16'd1;
        return 16'($urandom_range(int'(set_gap) + 1, 65535));
    endfunction

    // an interval inside the open pulse window, boundaries now and then
    function automatic logic [15:0] pulse_ticks();
        if (int'(set_max) <= int'(set_min) + 1)
            return 16'($urandom);
        case ($urandom_range(0, 9))
            0:       return set_min + 16'd1;
            1:       return set_max - 16'd1;
            default: return 16'($urandom_range(int'(set_min) + 1, int'(set_max) - 1));
        endcase
    endfunction

    // sync gap plus channels; a few clears and glitches break some frames up
    task automatic send_frame(int chans);
        send_interval(sync_ticks());
        for (int c = 0; c < chans; c++) begin
            if ($urandom_range(0, 99) < 4)
                send_item(OP_CLEAR, 16'($urandom), $urandom);
            else if ($urandom_range(0, 99) < 3)
                send_interval(16'($urandom));
            send_interval(pulse_ticks());
        end
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 3))
            0:       send_item(OP_CLEAR, 16'($urandom), $urandom);
            1:       send_item(OP_CAPTURE, 16'($urandom), $urandom);
            2:       send_interval(16'($urandom_range(0, int'(set_min))));  // short glitch
            default: send_interval(pulse_ticks());                          // stray pulse
        endcase
    endtask

    initial begin
        int  seg_end;
        bit  hold_done;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_valid      = 1'b0;
        operation     = OP_CAPTURE;
        capture_value = '0;
        now_time      = '0;
        last_capture  = '0;
        set_gap       = GapReset;
        set_min       = MinReset;
        set_max       = MaxReset;
        idle_pct      = 0;
        stall_pct     = 0;
        hold_request  = 1'b0;
        sent_items    = 0;
        cycle_count   = 0;
        hold_done     = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // --- directed ---
        // out of reset the decoder is disabled: captures only move the previous value
        send_item(OP_CAPTURE, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(OP_CLEAR, 16'h0000, 32'h0000_0000);
        apply_settings(1'b1, GapReset, MinReset, MaxReset);
        send_interval(16'd0);       // equal captures: zero interval, rejected
        send_interval(16'd1500);    // good pulse but no frame yet
        send_interval(16'd3000);    // exactly the gap threshold: not a sync
        send_interval(16'd3001);    // just above: frame start
        send_interval(16'd801);     // window edges, both inside
        send_interval(16'd2199);
        send_interval(16'd800);     // on the lower bound: rejected, frame dropped
        send_interval(16'hFFFF);    // full-range interval across the wrap: frame start
        send_interval(16'd2200);    // on the upper bound: rejected
        send_interval(16'd4000);
        for (int c = 0; c < 17; c++)
            send_interval(16'd1500);    // sixteen channels, then one past the limit
        send_item(OP_CLEAR, 16'hFFFF, 32'hFFFF_FFFF);

        // --- random, in segments of settings and idling ---
        for (int seg = 0; seg < 8; seg++) begin
            case (seg)
                0: apply_settings(1'b1, GapReset, MinReset, MaxReset);
                1: apply_settings(1'b1, 16'd0, 16'd0, 16'hFFFF);
                2: apply_settings(1'b0, GapReset, MinReset, MaxReset);
                3: apply_settings(1'b1, 16'hFFFF, 16'hFFFF, 16'd0);
                4: apply_settings(1'b1, 16'hFFFE, 16'd0, 16'hFFFF);
                5: apply_settings(1'b1, 16'($urandom_range(2500, 6000)),
                                  16'($urandom_range(500, 1000)),
                                  16'($urandom_range(1900, 2400)));
                6: apply_settings(1'b1, 16'd2500, 16'd1000, 16'd2000);
                default: apply_settings(1'b1, GapReset, MinReset, MaxReset);
            endcase
            case (seg % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 70; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 70; end
                default: begin idle_pct = 31; stall_pct = 31; end
            endcase
            seg_end = sent_items + SegmentItems;
            while (sent_items < seg_end) begin
                // one long receiver hold-off while items keep coming
                if (seg == 0 && !hold_done && sent_items >= seg_end - SegmentItems + 20) begin
                    hold_request = 1'b1;
                    hold_done = 1'b1;
                end
                if ($urandom_range(0, 4) == 0)
                    send_noise();
                else
                    send_frame($urandom_range(1, 18));
            end
        end

        wait_results_done();
        repeat (8) @(negedge clk);
        if (fail_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
